[sv/ddci_pkg.sv]
// Shared constants, types and the divide-by-slot-length helper for the dimming curve block.
package ddci_pkg;

    localparam int unsigned SLOTS     = 48;
    localparam int unsigned HALF_SLOTS = SLOTS / 2;

    localparam int unsigned SECS_W = 17;   // seconds of day before reduction
    localparam int unsigned NUM_W  = 18;   // interpolation numerator
    localparam int unsigned T_W    = 11;   // seconds into a slot
    localparam int unsigned PCT_W  = 7;    // percent value

    localparam logic [SECS_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [SECS_W-1:0] SECS_PER_MIN  = 17'd60;
    localparam logic [SECS_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [T_W-1:0]    SECS_PER_SLOT = 11'd1800;

    localparam logic [PCT_W-1:0] MAX_PERCENT = 7'd100;
    localparam logic [7:0]       NO_VALUE    = 8'hFF;
    localparam logic [5:0]       LAST_SLOT   = 6'd47;
    localparam logic [5:0]       SLOT_COUNT  = 6'd48;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // x / 1800 == (x >> 3) / 225; reciprocal 9321 / 2^21 is exact for x >> 3 below 28000
    localparam logic [13:0] DIV_MUL   = 14'd9321;
    localparam int unsigned DIV_SHIFT = 21;

    typedef struct packed {
        logic             en;
        logic             odd;
        logic [PCT_W-1:0] data;
    } t_curve_wr;

    function automatic logic [PCT_W-1:0] div_slot(input logic [NUM_W-1:0] x);
        logic [31:0] prod;
        prod = 32'(x[NUM_W-1:3]) * 32'(DIV_MUL);
        return prod[DIV_SHIFT+PCT_W-1:DIV_SHIFT];
    endfunction

endpackage

[sv/ddci_curve_mem.sv]
// Setpoint store split into even-slot and odd-slot banks, with a clearing pass after reset.
module ddci_curve_mem #(
    parameter int unsigned BANK_DEPTH = 192,
    parameter int unsigned BANK_AW    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [BANK_AW-1:0]       i_rd_addr_even,
    input  logic [BANK_AW-1:0]       i_rd_addr_odd,
    input  ddci_pkg::t_curve_wr      i_wr,
    input  logic [BANK_AW-1:0]       i_wr_addr,
    output logic [ddci_pkg::PCT_W-1:0] o_rd_even,
    output logic [ddci_pkg::PCT_W-1:0] o_rd_odd,
    output logic                     o_busy
);

    logic [ddci_pkg::PCT_W-1:0] r_mem_even [BANK_DEPTH];
    logic [ddci_pkg::PCT_W-1:0] r_mem_odd  [BANK_DEPTH];
    logic [ddci_pkg::PCT_W-1:0] r_rd_even;
    logic [ddci_pkg::PCT_W-1:0] r_rd_odd;
    logic                       r_busy;
    logic [BANK_AW-1:0]         r_clr_addr;

    // sweep both banks once, one row per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == BANK_AW'(BANK_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem_even[r_clr_addr] <= '0;
            r_mem_odd[r_clr_addr]  <= '0;
        end else if (i_wr.en) begin
            if (i_wr.odd) begin
                r_mem_odd[i_wr_addr] <= i_wr.data;
            end else begin
                r_mem_even[i_wr_addr] <= i_wr.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_even <= r_mem_even[i_rd_addr_even];
            r_rd_odd  <= r_mem_odd[i_rd_addr_odd];
        end
    end

    assign o_rd_even = r_rd_even;
    assign o_rd_odd  = r_rd_odd;
    assign o_busy    = r_busy;

endmodule

[sv/daily_dimming_curve_interpolator.sv]
// Top level of the daily dimming curve interpolator: five-stage pipeline and output register.
//
// Each LED channel holds 48 half-hour percent setpoints. A write item (func 0) stores one
// setpoint, saturated to 100, and yields no result; writes to a channel at or above CHANNELS
// or to a slot above 47 are dropped. A query item (func 1) turns hour:minute:second into
// seconds of the day (modulo one day), picks the half-hour slot and interpolates linearly
// toward the next slot (slot 47 wraps to slot 0) with floor arithmetic. Each query yields
// exactly one result: the power and a changed flag that is set when the power differs from
// the last value reported for that channel; the first query of a channel always sets it.
// A query to a channel at or above CHANNELS returns power 0, changed 0 and touches no state.
// The block takes one item per cycle while o_stall is low; each query passes through the
// stage registers and the output register. The rate is set by the setpoint store, which
// is split by slot parity so both neighbouring setpoints come out of a single read. After
// reset the store is cleared row by row, and o_stall stays high until every row is cleared.
module daily_dimming_curve_interpolator #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item input
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_func,
    input  logic [2:0] i_channel,
    input  logic [5:0] i_slot,
    input  logic [6:0] i_setpoint,
    input  logic [4:0] i_hour,
    input  logic [5:0] i_minute,
    input  logic [5:0] i_second,
    // result output
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_power,
    output logic       o_changed
);

    // The channel field is three bits wide, so at most eight channels are reachable.
    localparam int unsigned CH_USE     = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int unsigned BANK_DEPTH = CH_USE * ddci_pkg::HALF_SLOTS;
    localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);
    localparam int unsigned LP_AW      = (CH_USE > 1) ? $clog2(CH_USE) : 1;

    localparam int unsigned PW = ddci_pkg::PCT_W;

    // ---------------------------------------------------------------- pipeline control
    // The whole pipeline advances unless a result is waiting and the sink stalls.
    logic mem_busy;
    logic adv;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = mem_busy || !adv;

    // ---------------------------------------------------------------- stage 1: input register
    logic        r1_valid;
    logic        r1_func;
    logic [2:0]  r1_ch;
    logic [5:0]  r1_slot;
    logic [6:0]  r1_sp;
    logic [4:0]  r1_hour;
    logic [5:0]  r1_min;
    logic [5:0]  r1_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= i_valid && !mem_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_func <= i_func;
            r1_ch   <= i_channel;
            r1_slot <= i_slot;
            r1_sp   <= i_setpoint;
            r1_hour <= i_hour;
            r1_min  <= i_minute;
            r1_sec  <= i_second;
        end
    end

    // Seconds of day; the raw sum stays below two days, so one subtraction reduces it.
    logic [ddci_pkg::SECS_W-1:0] n_secs_raw;
    logic [ddci_pkg::SECS_W-1:0] n_secs;
    logic                        n_chok;

    always_comb begin
        n_secs_raw = ddci_pkg::SECS_W'(r1_hour) * ddci_pkg::SECS_PER_HOUR
                   + ddci_pkg::SECS_W'(r1_min) * ddci_pkg::SECS_PER_MIN
                   + ddci_pkg::SECS_W'(r1_sec);
        n_secs = (n_secs_raw >= ddci_pkg::SECS_PER_DAY) ?
                 n_secs_raw - ddci_pkg::SECS_PER_DAY : n_secs_raw;
        n_chok = {4'd0, r1_ch} < 7'(CHANNELS);
    end

    // ---------------------------------------------------------------- stage 2: slot select
    logic                        r2_valid;
    logic                        r2_func;
    logic                        r2_chok;
    logic [2:0]                  r2_ch;
    logic [5:0]                  r2_slot;
    logic [6:0]                  r2_sp;
    logic [ddci_pkg::SECS_W-1:0] r2_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_func <= r1_func;
            r2_chok <= n_chok;
            r2_ch   <= r1_ch;
            r2_slot <= r1_slot;
            r2_sp   <= r1_sp;
            r2_secs <= n_secs;
        end
    end

    // seconds of day are below one day, so the slot is at most 47
    logic [5:0] n_s0;

    assign n_s0 = 6'(ddci_pkg::div_slot(ddci_pkg::NUM_W'(r2_secs)));

    // ---------------------------------------------------------------- stage 3: store access
    logic                        r3_valid;
    logic                        r3_func;
    logic                        r3_chok;
    logic [2:0]                  r3_ch;
    logic [5:0]                  r3_slot;
    logic [6:0]                  r3_sp;
    logic [ddci_pkg::SECS_W-1:0] r3_secs;
    logic [5:0]                  r3_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_func <= r2_func;
            r3_chok <= r2_chok;
            r3_ch   <= r2_ch;
            r3_slot <= r2_slot;
            r3_sp   <= r2_sp;
            r3_secs <= r2_secs;
            r3_s0   <= n_s0;
        end
    end

    // Slot s0 and its successor always differ in parity: an even s0 reads both from the same
    // row; an odd s0 takes the even neighbour from the next row, or row 0 after slot 47.
    logic [7:0]                 n_row_base;
    logic [4:0]                 n_even_half;
    logic [BANK_AW-1:0]         n_rd_addr_even;
    logic [BANK_AW-1:0]         n_rd_addr_odd;
    logic [BANK_AW-1:0]         n_wr_addr;
    logic [ddci_pkg::T_W-1:0]   n_t;
    logic                       n_rd_en;
    ddci_pkg::t_curve_wr        n_wr;

    always_comb begin
        n_row_base = {1'b0, r3_ch, 4'd0} + {2'd0, r3_ch, 3'd0};
        if (!r3_s0[0]) begin
            n_even_half = r3_s0[5:1];
        end else if (r3_s0 == ddci_pkg::LAST_SLOT) begin
            n_even_half = '0;
        end else begin
            n_even_half = r3_s0[5:1] + 5'd1;
        end
        n_rd_addr_even = BANK_AW'(n_row_base + {3'd0, n_even_half});
        n_rd_addr_odd  = BANK_AW'(n_row_base + {3'd0, r3_s0[5:1]});
        n_wr_addr      = BANK_AW'(n_row_base + {3'd0, r3_slot[5:1]});

        n_t = ddci_pkg::T_W'(r3_secs - ddci_pkg::SECS_W'(r3_s0)
                                       * ddci_pkg::SECS_W'(ddci_pkg::SECS_PER_SLOT));

        n_rd_en = adv && r3_valid && (r3_func == ddci_pkg::FUNC_QUERY) && r3_chok;

        n_wr.en   = adv && r3_valid && (r3_func == ddci_pkg::FUNC_WRITE) && r3_chok
                    && (r3_slot < ddci_pkg::SLOT_COUNT);
        n_wr.odd  = r3_slot[0];
        n_wr.data = (r3_sp > ddci_pkg::MAX_PERCENT) ? ddci_pkg::MAX_PERCENT : r3_sp;
    end

    logic [PW-1:0] rd_even;
    logic [PW-1:0] rd_odd;

    ddci_curve_mem #(
        .BANK_DEPTH (BANK_DEPTH),
        .BANK_AW    (BANK_AW)
    ) u_curve_mem (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd_en        (n_rd_en),
        .i_rd_addr_even (n_rd_addr_even),
        .i_rd_addr_odd  (n_rd_addr_odd),
        .i_wr           (n_wr),
        .i_wr_addr      (n_wr_addr),
        .o_rd_even      (rd_even),
        .o_rd_odd       (rd_odd),
        .o_busy         (mem_busy)
    );

    // ---------------------------------------------------------------- stage 4: weighted sum
    logic                     r4_valid;
    logic                     r4_func;
    logic                     r4_chok;
    logic [2:0]               r4_ch;
    logic [ddci_pkg::T_W-1:0] r4_t;
    logic                     r4_swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (adv) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_func <= r3_func;
            r4_chok <= r3_chok;
            r4_ch   <= r3_ch;
            r4_t    <= n_t;
            r4_swap <= r3_s0[0];
        end
    end

    logic [PW-1:0]              n_p0;
    logic [PW-1:0]              n_p1;
    logic [ddci_pkg::NUM_W-1:0] n_num;

    always_comb begin
        n_p0  = r4_swap ? rd_odd : rd_even;
        n_p1  = r4_swap ? rd_even : rd_odd;
        n_num = ddci_pkg::NUM_W'(n_p0) * ddci_pkg::NUM_W'(ddci_pkg::SECS_PER_SLOT - r4_t)
              + ddci_pkg::NUM_W'(n_p1) * ddci_pkg::NUM_W'(r4_t);
    end

    // ---------------------------------------------------------------- stage 5: divide, compare
    logic                       r5_valid;
    logic                       r5_func;
    logic                       r5_chok;
    logic [2:0]                 r5_ch;
    logic [ddci_pkg::NUM_W-1:0] r5_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (adv) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_func <= r4_func;
            r5_chok <= r4_chok;
            r5_ch   <= r4_ch;
            r5_num  <= n_num;
        end
    end

    // last reported power per channel; all ones means nothing reported yet
    logic [7:0] r_last [CH_USE];

    logic [PW-1:0] n_power;
    logic          n_changed;
    logic          n_upd;

    always_comb begin
        n_power   = ddci_pkg::div_slot(r5_num);
        n_changed = {1'b0, n_power} != r_last[LP_AW'(r5_ch)];
        n_upd     = adv && r5_valid && (r5_func == ddci_pkg::FUNC_QUERY) && r5_chok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CH_USE; i++) begin
                r_last[i] <= ddci_pkg::NO_VALUE;
            end
        end else if (n_upd) begin
            r_last[LP_AW'(r5_ch)] <= {1'b0, n_power};
        end
    end

    // ---------------------------------------------------------------- output register
    logic          r_out_valid;
    logic [PW-1:0] r_power;
    logic          r_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r5_valid && (r5_func == ddci_pkg::FUNC_QUERY);
        end
    end

    // an unknown channel reports zero power and no change
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_power   <= r5_chok ? n_power : '0;
            r_changed <= r5_chok && n_changed;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_power   = r_power;
    assign o_changed = r_changed;

endmodule
